>>> rtl/etur_pkg.sv
// ----------------------------------------------------------------------------
// etur_pkg
// Shared types and constants of the edge-timed serial receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package etur_pkg;

    // request kinds
    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_PEEK  = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    // frame layout: start bit, eight data bits, stop bit
    localparam logic [3:0] LAST_BIT = 4'd9;
    localparam int unsigned QUARTER_SHIFT = 2;
    localparam logic [23:0] BIT_TIME_RESET = 24'd8333;

    typedef struct packed {
        logic [1:0]  mode;
        logic        line_level;
        logic [31:0] edge_time;
    } etur_in_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [7:0]  fill_count;
        logic        byte_stored;
        logic        byte_dropped;
    } etur_out_t;

endpackage

`default_nettype wire

>>> rtl/edge_timed_uart_receiver_core.sv
// ----------------------------------------------------------------------------
// edge_timed_uart_receiver_core
// Edge-timed 8N1 serial receiver with a byte FIFO.
// ----------------------------------------------------------------------------
// Each request is a line edge (level and 32-bit tick count) or a read, peek or
// flush of the byte FIFO, and produces exactly one result. Requests pass a
// two-entry queue to a sequential back end that handles one at a time, so it
// takes the next request only after the previous one has committed. An edge
// inside a frame is registered into the back end, runs the 32 steps of the
// serial divider that turns elapsed ticks into a bit number, has the quotient
// picked up and then commits; other requests are registered and then commit.
// While a result is stalled the back end holds, and the queue takes up to two
// more requests before item_stall rises. The FIFO holds FIFO_DEPTH-1 bytes.
// The user must write the bit time register with cfg_we and cfg_data only
// while no request is in flight; the block itself does not enforce it.
`default_nettype none

module edge_timed_uart_receiver_core #(
    parameter int FIFO_DEPTH = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [23:0]         cfg_data,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire etur_pkg::etur_in_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output etur_pkg::etur_out_t      result
);

    logic               q_valid;
    logic               q_pop;
    etur_pkg::etur_in_t q_data;

    // request queue
    etur_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop)
    );

    // decoding and FIFO
    etur_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> rtl/etur_front.sv
// ----------------------------------------------------------------------------
// etur_front
// Two-entry request queue between the input channel and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module etur_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire etur_pkg::etur_in_t item,
    output logic                   q_valid,
    output etur_pkg::etur_in_t     q_data,
    input  wire logic              q_pop
);

    etur_pkg::etur_in_t slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       tail;

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != 2'd0);
    assign q_data     = slot_reg[head_reg];
    assign tail       = head_reg ^ count_reg[0];

    // occupancy and head pointer
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (q_pop && q_valid)
        begin
            head_next  = ~head_reg;
            count_next = count_next - 2'd1;
        end
        if (push)
            count_next = count_next + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // request storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[tail] <= item;
    end

endmodule

`default_nettype wire

>>> rtl/etur_div.sv
// ----------------------------------------------------------------------------
// etur_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module etur_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [23:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [23:0] rem_reg;
    logic [31:0] quo_reg;
    logic [23:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [24:0] shifted;
    logic [25:0] trial;

    assign shifted  = {rem_reg, quo_reg[31]};
    assign trial    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, the remainder always stays below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 24'd0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[25])
            begin
                rem_reg <= trial[23:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[23:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/etur_back.sv
// ----------------------------------------------------------------------------
// etur_back
// Frame decoding, byte FIFO and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module etur_back #(
    parameter int FIFO_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               q_valid,
    input  wire etur_pkg::etur_in_t q_data,
    output logic                    q_pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output etur_pkg::etur_out_t     result
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    etur_pkg::etur_in_t req_reg;
    logic [23:0] bit_time_reg;
    logic [3:0]  bit_pos_reg, bit_pos_next;
    logic [9:0]  frame_bits_reg, frame_bits_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [PW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [7:0]  rd_data_reg;
    logic [7:0]  mem [FIFO_DEPTH];
    etur_pkg::etur_out_t out_reg, out_next;
    logic        out_valid_reg;

    logic        slot_free;
    logic        commit;
    logic [23:0] tpb;
    logic        div_start, div_busy, div_done;
    logic [31:0] quo;
    logic        need_div;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic [9:0]  fill_mask;
    logic [3:0]  fill_lim;
    logic [9:0]  push_bits;
    logic        do_push;
    logic [PW-1:0] wp_inc, rp_inc;
    logic [PW:0] fill;

    assign tpb       = (bit_time_reg == 24'd0) ? 24'd1 : bit_time_reg;
    assign slot_free = !out_valid_reg || !result_stall;
    assign commit    = (state_reg == ST_DONE) && slot_free;
    assign need_div  = (q_data.mode == etur_pkg::MODE_EDGE) && (bit_pos_reg != 4'd0);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign div_start = q_pop && need_div;
    assign wp_inc    = (wp_reg == PTR_LAST) ? '0 : wp_reg + PW'(1);
    assign rp_inc    = (rp_reg == PTR_LAST) ? '0 : rp_reg + PW'(1);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    etur_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_data.edge_time - start_time_reg),
        .divisor  (tpb),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    // fill mask for bits from the current position up to the limit
    always_comb
    begin
        fill_lim = (quo > 32'd9) ? 4'd10 : quo[3:0];
        for (int i = 0; i < 10; i++)
            fill_mask[i] = (4'(i) >= bit_pos_reg) && (4'(i) < fill_lim);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                    state_next = need_div ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // request execution
    always_comb
    begin
        bit_pos_next    = bit_pos_reg;
        frame_bits_next = frame_bits_reg;
        start_time_next = start_time_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        push_bits       = frame_bits_reg;
        do_push         = 1'b0;
        out_next        = '0;
        case (req_reg.mode)
            etur_pkg::MODE_EDGE:
            begin
                if (bit_pos_reg == 4'd0)
                begin
                    if (!req_reg.line_level)
                    begin
                        start_time_next = req_reg.edge_time
                                        - 32'(tpb >> etur_pkg::QUARTER_SHIFT);
                        frame_bits_next = 10'd0;
                        bit_pos_next    = 4'd1;
                    end
                end
                else if (!req_reg.line_level && quo > 32'(etur_pkg::LAST_BIT))
                begin
                    push_bits       = frame_bits_reg | fill_mask;
                    do_push         = 1'b1;
                    start_time_next = req_reg.edge_time
                                    - 32'(tpb >> etur_pkg::QUARTER_SHIFT);
                    frame_bits_next = 10'd0;
                    bit_pos_next    = 4'd1;
                end
                else if (quo >= 32'(etur_pkg::LAST_BIT))
                begin
                    do_push         = 1'b1;
                    frame_bits_next = 10'd0;
                    bit_pos_next    = 4'd0;
                end
                else
                begin
                    if (!req_reg.line_level)
                        frame_bits_next = frame_bits_reg | fill_mask;
                    bit_pos_next = quo[3:0];
                end
                if (do_push)
                begin
                    if (wp_inc == rp_reg)
                        out_next.byte_dropped = 1'b1;
                    else
                    begin
                        out_next.byte_stored = 1'b1;
                        wp_next = wp_inc;
                    end
                end
            end
            etur_pkg::MODE_READ, etur_pkg::MODE_PEEK:
            begin
                if (wp_reg != rp_reg)
                begin
                    out_next.data_valid = 1'b1;
                    out_next.data_byte  = rd_data_reg;
                    if (req_reg.mode == etur_pkg::MODE_READ)
                        rp_next = rp_inc;
                end
            end
            etur_pkg::MODE_FLUSH:
            begin
                wp_next = '0;
                rp_next = '0;
            end
            default: ;
        endcase
        fill = (wp_next >= rp_next) ? {1'b0, wp_next} - {1'b0, rp_next}
                                    : {1'b0, wp_next} + (PW+1)'(FIFO_DEPTH) - {1'b0, rp_next};
        out_next.fill_count = 8'(fill);
        mem_we    = commit && out_next.byte_stored;
        mem_wdata = push_bits[8:1];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bit_time_reg   <= etur_pkg::BIT_TIME_RESET;
            bit_pos_reg    <= 4'd0;
            frame_bits_reg <= 10'd0;
            start_time_reg <= 32'd0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                bit_time_reg <= cfg_data;
            if (commit)
            begin
                bit_pos_reg    <= bit_pos_next;
                frame_bits_reg <= frame_bits_next;
                start_time_reg <= start_time_next;
                wp_reg         <= wp_next;
                rp_reg         <= rp_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
            req_reg <= q_data;
        if (commit)
            out_reg <= out_next;
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= mem_wdata;
        if (q_pop)
            rd_data_reg <= mem[rp_reg];
    end

`ifndef SYNTH
    // the divider is only started when it is free
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider restarted while busy");
    // a frame position never passes the stop bit
    assert property (@(posedge clk) disable iff (!rst_n) bit_pos_reg <= etur_pkg::LAST_BIT)
        else $error("bit position out of range");
    // a stored byte and a dropped byte never come from one request
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !(out_next.byte_stored && out_next.byte_dropped))
        else $error("byte both stored and dropped");
    // the divider only finishes while a request waits for it
    assert property (@(posedge clk) disable iff (!rst_n) div_done |-> state_reg == ST_DIV)
        else $error("divider result without a waiting request");
`endif

endmodule

`default_nettype wire
